[hdl/bdlp_pkg.sv]
package bdlp_pkg;

   // pwm and colour table
   localparam int unsigned PWM_PERIOD = 512;
   localparam int unsigned PWM_W      = $clog2(PWM_PERIOD);
   localparam int unsigned NUM_COLORS = 3;

   // full scale of a level is 1 << FULL_SCALE_SHIFT
   localparam int unsigned FULL_SCALE_SHIFT = 9;
   localparam int unsigned CMP_W            = PWM_W + 11;

   // yellow adds roughly 0.15 of its level on the green side
   localparam logic [6:0] YELLOW_GREEN_MUL = 7'd77;

   localparam int unsigned LEVEL_W = 10;
   localparam int unsigned DUR_W   = 24;
   localparam int unsigned CSR_W   = 16;

   localparam logic [CSR_W-1:0] DEBOUNCE_LEN_RESET = 16'd480;
   localparam logic [CSR_W-1:0] BLOCK_US_RESET     = 16'd1000;

   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_BLOCK  = 2'd1,
      REQ_SET    = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      COLOR_RED    = 2'd0,
      COLOR_GREEN  = 2'd1,
      COLOR_YELLOW = 2'd2,
      COLOR_ALL    = 2'd3
   } color_type;

   typedef enum logic {
      CSR_DEBOUNCE_LEN = 1'b0,
      CSR_BLOCK_US     = 1'b1
   } csr_index_type;

   // command from the request decoder to the colour bank
   typedef struct packed {
      logic               block_en;
      logic               set_en;
      logic [1:0]         style;
      color_type          color;
      logic [LEVEL_W-1:0] intensity;
      logic [DUR_W-1:0]   duration;
   } color_cmd_type;

endpackage

[hdl/bdlp_color_bank.sv]
module bdlp_color_bank (
   input  logic                          clock,
   input  logic                          reset,
   input  bdlp_pkg::color_cmd_type       cmd,
   input  logic [bdlp_pkg::CSR_W-1:0]    block_us,
   output logic [bdlp_pkg::LEVEL_W-1:0]  level_green,
   output logic [bdlp_pkg::LEVEL_W-1:0]  level_red
);

   logic [1:0]                    style_ff     [bdlp_pkg::NUM_COLORS];
   logic [1:0]                    style_in     [bdlp_pkg::NUM_COLORS];
   logic [bdlp_pkg::LEVEL_W-1:0]  lvl_ff       [bdlp_pkg::NUM_COLORS];
   logic [bdlp_pkg::LEVEL_W-1:0]  lvl_in       [bdlp_pkg::NUM_COLORS];
   logic [bdlp_pkg::DUR_W-1:0]    remaining_ff [bdlp_pkg::NUM_COLORS];
   logic [bdlp_pkg::DUR_W-1:0]    remaining_in [bdlp_pkg::NUM_COLORS];
   logic [bdlp_pkg::LEVEL_W-1:0]  green_ff, green_in;
   logic [bdlp_pkg::LEVEL_W-1:0]  red_ff, red_in;
   logic [bdlp_pkg::NUM_COLORS-1:0] active;
   logic [16:0]                   yellow_prod;
   logic [bdlp_pkg::LEVEL_W-1:0]  yellow_green;

   always_comb begin
      for (int c = 0; c < bdlp_pkg::NUM_COLORS; c++) begin
         active[c] = (remaining_ff[c] != '0) && (style_ff[c] != 2'd0) && (lvl_ff[c] != '0);
      end
      yellow_prod  = 17'(lvl_ff[bdlp_pkg::COLOR_YELLOW]) * 17'(bdlp_pkg::YELLOW_GREEN_MUL);
      yellow_green = bdlp_pkg::LEVEL_W'(yellow_prod >> bdlp_pkg::FULL_SCALE_SHIFT);
   end

   always_comb begin
      green_in = green_ff;
      red_in   = red_ff;
      for (int c = 0; c < bdlp_pkg::NUM_COLORS; c++) begin
         style_in[c]     = style_ff[c];
         lvl_in[c]       = lvl_ff[c];
         remaining_in[c] = remaining_ff[c];
      end

      if (cmd.block_en) begin
         // later colours override earlier ones
         green_in = '0;
         red_in   = '0;
         if (active[bdlp_pkg::COLOR_RED]) begin
            red_in = lvl_ff[bdlp_pkg::COLOR_RED];
         end
         if (active[bdlp_pkg::COLOR_GREEN]) begin
            green_in = lvl_ff[bdlp_pkg::COLOR_GREEN];
         end
         if (active[bdlp_pkg::COLOR_YELLOW]) begin
            green_in = yellow_green;
            red_in   = lvl_ff[bdlp_pkg::COLOR_YELLOW];
         end
         // countdown saturates at zero
         for (int c = 0; c < bdlp_pkg::NUM_COLORS; c++) begin
            if (remaining_ff[c] > bdlp_pkg::DUR_W'(block_us)) begin
               remaining_in[c] = remaining_ff[c] - bdlp_pkg::DUR_W'(block_us);
            end else begin
               remaining_in[c] = '0;
            end
         end
      end else if (cmd.set_en) begin
         for (int c = 0; c < bdlp_pkg::NUM_COLORS; c++) begin
            if ((cmd.color == bdlp_pkg::color_type'(c)) || (cmd.color == bdlp_pkg::COLOR_ALL)) begin
               style_in[c]     = cmd.style;
               lvl_in[c]       = cmd.intensity;
               remaining_in[c] = cmd.duration;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         green_ff <= '0;
         red_ff   <= '0;
         for (int c = 0; c < bdlp_pkg::NUM_COLORS; c++) begin
            style_ff[c]     <= '0;
            lvl_ff[c]       <= '0;
            remaining_ff[c] <= '0;
         end
      end else begin
         green_ff <= green_in;
         red_ff   <= red_in;
         for (int c = 0; c < bdlp_pkg::NUM_COLORS; c++) begin
            style_ff[c]     <= style_in[c];
            lvl_ff[c]       <= lvl_in[c];
            remaining_ff[c] <= remaining_in[c];
         end
      end
   end

   assign level_green = green_ff;
   assign level_red   = red_ff;

endmodule

[hdl/button_debounce_and_led_pwm_top.sv]
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tuser: request kind, tdata: button and colour fields
// rsp     | out | rsp_tvalid/rsp_tready | tdata: debounced level, two led pins
// csr     | in  | csr_valid/csr_ready   | csr_index, csr_data (16 bit)
//
// one request per clock unless a held response stalls it; its response is registered
// and shows in the next cycle. the response register holds while rsp_tready is low;
// a new request is then taken only in a cycle where the held response leaves
// reset (synchronous) clears debounce, pwm and colour state, registers to 480 and 1000
// csr writes are always taken, one per clock
module button_debounce_and_led_pwm_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   // [0] button_raw, [2:1] led_style, [4:3] led_color, [14:5] led_intensity,
   // [38:15] duration_us, [39] zero
   input  logic [39:0] req_tdata,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] button_level, [1] led_pin0, [2] led_pin1, [7:3] zero

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   localparam logic [bdlp_pkg::CMP_W-1:0] PERIOD_C = bdlp_pkg::CMP_W'(bdlp_pkg::PWM_PERIOD);
   localparam logic [bdlp_pkg::PWM_W-1:0] LAST_IDX = bdlp_pkg::PWM_W'(bdlp_pkg::PWM_PERIOD - 1);

   logic                          req_acc;
   bdlp_pkg::req_kind_type        kind;
   logic                          raw;
   bdlp_pkg::color_cmd_type       cmd;

   logic [bdlp_pkg::CSR_W-1:0]    debounce_len_ff, debounce_len_in;
   logic [bdlp_pkg::CSR_W-1:0]    block_us_ff, block_us_in;

   logic                          button_state_ff, button_state_in;
   logic [bdlp_pkg::CSR_W-1:0]    holdoff_ff, holdoff_in;
   logic [bdlp_pkg::PWM_W-1:0]    pwm_index_ff, pwm_index_in;

   logic [bdlp_pkg::LEVEL_W-1:0]  level_green, level_red, level_sel;
   logic                          pin_on, pin0, pin1;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_level_ff, rsp_level_in;
   logic                          rsp_pin0_ff, rsp_pin0_in;
   logic                          rsp_pin1_ff, rsp_pin1_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign kind = bdlp_pkg::req_kind_type'(req_tuser);
   assign raw  = req_tdata[0];

   always_comb begin
      cmd.block_en  = req_acc && (kind == bdlp_pkg::REQ_BLOCK);
      cmd.set_en    = req_acc && (kind == bdlp_pkg::REQ_SET);
      cmd.style     = req_tdata[2:1];
      cmd.color     = bdlp_pkg::color_type'(req_tdata[4:3]);
      cmd.intensity = req_tdata[14:5];
      cmd.duration  = req_tdata[38:15];
   end

   always_comb begin
      debounce_len_in = debounce_len_ff;
      block_us_in     = block_us_ff;
      if (csr_valid && csr_ready) begin
         unique case (bdlp_pkg::csr_index_type'(csr_index))
            bdlp_pkg::CSR_DEBOUNCE_LEN: debounce_len_in = csr_data;
            bdlp_pkg::CSR_BLOCK_US:     block_us_in     = csr_data;
            default: ;
         endcase
      end
   end

   // pwm phase: even index drives the green side, odd the red side
   assign level_sel = pwm_index_ff[0] ? level_red : level_green;
   assign pin_on    = (bdlp_pkg::CMP_W'(pwm_index_ff) << bdlp_pkg::FULL_SCALE_SHIFT)
                      < (bdlp_pkg::CMP_W'(level_sel) * PERIOD_C);

   always_comb begin
      button_state_in = button_state_ff;
      holdoff_in      = holdoff_ff;
      pwm_index_in    = pwm_index_ff;
      pin0            = 1'b0;
      pin1            = 1'b0;
      if (req_acc && (kind == bdlp_pkg::REQ_SAMPLE)) begin
         if (holdoff_ff != '0) begin
            holdoff_in = holdoff_ff - 1'b1;
         end else begin
            if (raw != button_state_ff) begin
               holdoff_in = debounce_len_ff;
            end
            button_state_in = raw;
         end
         pin0 = pin_on && !pwm_index_ff[0];
         pin1 = pin_on && pwm_index_ff[0];
         if (pwm_index_ff == LAST_IDX) begin
            pwm_index_in = '0;
         end else begin
            pwm_index_in = pwm_index_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;
      rsp_pin0_in  = rsp_pin0_ff;
      rsp_pin1_in  = rsp_pin1_ff;
      if (req_tready) begin
         rsp_valid_in = req_acc;
      end
      if (req_acc) begin
         rsp_level_in = button_state_in;
         rsp_pin0_in  = pin0;
         rsp_pin1_in  = pin1;
      end
   end

   bdlp_color_bank u_color_bank (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .block_us    (block_us_ff),
      .level_green (level_green),
      .level_red   (level_red)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_len_ff <= bdlp_pkg::DEBOUNCE_LEN_RESET;
         block_us_ff     <= bdlp_pkg::BLOCK_US_RESET;
         button_state_ff <= 1'b0;
         holdoff_ff      <= '0;
         pwm_index_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         debounce_len_ff <= debounce_len_in;
         block_us_ff     <= block_us_in;
         button_state_ff <= button_state_in;
         holdoff_ff      <= holdoff_in;
         pwm_index_ff    <= pwm_index_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_level_ff <= rsp_level_in;
      rsp_pin0_ff  <= rsp_pin0_in;
      rsp_pin1_ff  <= rsp_pin1_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_pin1_ff, rsp_pin0_ff, rsp_level_ff};

   // only sample requests move the pwm
   a_pwm_only_on_sample: assert property (@(posedge clock) disable iff (reset)
      req_acc && (kind != bdlp_pkg::REQ_SAMPLE) |=> $stable(pwm_index_ff))
      else $error("pwm index moved on a non-sample request");

   // raw level is ignored during hold-off
   a_holdoff_keeps_level: assert property (@(posedge clock) disable iff (reset)
      req_acc && (kind == bdlp_pkg::REQ_SAMPLE) && (holdoff_ff != '0)
      |=> $stable(button_state_ff))
      else $error("button level changed during hold-off");

   a_pins_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_pin0_ff && rsp_pin1_ff))
      else $error("both led pins driven together");

   a_pwm_in_range: assert property (@(posedge clock) disable iff (reset)
      pwm_index_ff <= LAST_IDX)
      else $error("pwm index out of range");

endmodule

[test/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned QUIET_LIMIT = 1500;
   localparam int unsigned HOLD_CYCLES = 200;
   localparam int unsigned DIR_ROWS    = 25;

   typedef struct packed {
      bdlp_pkg::req_kind_type       kind;
      logic                         raw;
      logic [1:0]                   style;
      bdlp_pkg::color_type          color;
      logic [bdlp_pkg::LEVEL_W-1:0] intensity;
      logic [bdlp_pkg::DUR_W-1:0]   duration;
   } led_req_type;

   // known = 1: rsp is read off by hand, otherwise the predictor decides
   typedef struct packed {
      led_req_type req;
      logic        known;
      logic [2:0]  rsp;
   } led_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [15:0] csr_data;

   button_debounce_and_led_pwm_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // predictor state
   logic [bdlp_pkg::CSR_W-1:0]   deb_len;
   int unsigned                  blk_us;
   logic                         btn_state;
   logic [bdlp_pkg::CSR_W-1:0]   holdoff;
   int unsigned                  pwm_idx;
   int unsigned                  drive_lvl [2];
   logic [1:0]                   col_style [bdlp_pkg::NUM_COLORS];
   logic [bdlp_pkg::LEVEL_W-1:0] col_lvl   [bdlp_pkg::NUM_COLORS];
   int unsigned                  col_rem   [bdlp_pkg::NUM_COLORS];

   logic [2:0]  awaited_button_leds [$];
   logic [2:0]  want;
   int          errors;
   int unsigned quiet_cycles;
   bit          no_idle;
   bit          hold_rsp_req;
   logic        raw_level;
   led_row_type dir_rows [DIR_ROWS];
   string       rsp_field_name [3] = '{"button_level", "led_pin0", "led_pin1"};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void refresh_levels();
      int unsigned yl;
      drive_lvl[0] = 0;
      drive_lvl[1] = 0;
      for (int c = 0; c < bdlp_pkg::NUM_COLORS; c++) begin
         if (col_rem[c] != 0 && col_style[c] != 2'd0 && col_lvl[c] != '0) begin
            case (bdlp_pkg::color_type'(c))
               bdlp_pkg::COLOR_RED:   drive_lvl[1] = col_lvl[c];
               bdlp_pkg::COLOR_GREEN: drive_lvl[0] = col_lvl[c];
               default: begin
                  // yellow puts a little green under its red
                  yl = col_lvl[c] * bdlp_pkg::YELLOW_GREEN_MUL;
                  drive_lvl[0] = yl >> bdlp_pkg::FULL_SCALE_SHIFT;
                  drive_lvl[1] = col_lvl[c];
               end
            endcase
         end
         if (col_rem[c] != 0)
            col_rem[c] = (col_rem[c] > blk_us) ? col_rem[c] - blk_us : 0;
      end
   endfunction

   function automatic logic [2:0] step_button_leds(input led_req_type it);
      logic [1:0]  pins;
      int unsigned ph;
      pins = 2'b00;
      case (it.kind)
         bdlp_pkg::REQ_SAMPLE: begin
            if (holdoff != '0) begin
               holdoff = holdoff - 1'b1;
            end else begin
               if (it.raw != btn_state)
                  holdoff = deb_len;
               btn_state = it.raw;
            end
            ph = pwm_idx & 1;
            if (pwm_idx * (1 << bdlp_pkg::FULL_SCALE_SHIFT) <
                drive_lvl[ph] * bdlp_pkg::PWM_PERIOD)
               pins[ph] = 1'b1;
            pwm_idx = (pwm_idx + 1 >= bdlp_pkg::PWM_PERIOD) ? 0 : pwm_idx + 1;
         end
         bdlp_pkg::REQ_BLOCK: refresh_levels();
         bdlp_pkg::REQ_SET: begin
            for (int c = 0; c < bdlp_pkg::NUM_COLORS; c++) begin
               if (it.color == bdlp_pkg::COLOR_ALL || it.color == bdlp_pkg::color_type'(c)) begin
                  col_style[c] = it.style;
                  col_lvl[c]   = it.intensity;
                  col_rem[c]   = it.duration;
               end
            end
         end
         default: ;
      endcase
      return {pins[1], pins[0], btn_state};
   endfunction

   function automatic led_req_type random_request();
      led_req_type it;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      // a bouncy button: the raw level flips now and then
      if ($urandom_range(0, 3) == 0)
         raw_level = ~raw_level;
      it.kind  = (pick < 65) ? bdlp_pkg::REQ_SAMPLE : (pick < 78) ? bdlp_pkg::REQ_BLOCK :
                 (pick < 96) ? bdlp_pkg::REQ_SET : bdlp_pkg::REQ_NONE;
      it.raw   = raw_level;
      it.style = 2'($urandom_range(0, 3));
      it.color = bdlp_pkg::color_type'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
         0:       it.intensity = '0;
         1:       it.intensity = bdlp_pkg::LEVEL_W'(1 << bdlp_pkg::FULL_SCALE_SHIFT);
         2:       it.intensity = '1;
         3:       it.intensity = bdlp_pkg::LEVEL_W'($urandom_range(1, 511));
         default: it.intensity = bdlp_pkg::LEVEL_W'($urandom_range(0, 1023));
      endcase
      case ($urandom_range(0, 6))
         0:       it.duration = '0;
         1:       it.duration = '1;
         2:       it.duration = bdlp_pkg::DUR_W'($urandom_range(1, blk_us));
         3:       it.duration = bdlp_pkg::DUR_W'($urandom);
         default: it.duration = bdlp_pkg::DUR_W'($urandom_range(1, 40000));
      endcase
      return it;
   endfunction

   task automatic push_request(input led_req_type it, input logic known, input logic [2:0] rsp);
      logic [2:0] predicted;
      if (!no_idle && $urandom_range(0, 7) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = it.kind;
      req_tdata  = {1'b0, it.duration, it.intensity, it.color, it.style, it.raw};
      do @(posedge clock); while (!req_tready);
      predicted = step_button_leds(it);
      awaited_button_leds.push_back(known ? rsp : predicted);
      @(negedge clock);
   endtask

   task automatic write_csr(input bdlp_pkg::csr_index_type idx,
                            input logic [bdlp_pkg::CSR_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      if (idx == bdlp_pkg::CSR_DEBOUNCE_LEN)
         deb_len = value;
      else
         blk_us = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (awaited_button_leds.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_random(input int n, input logic [bdlp_pkg::CSR_W-1:0] dl,
                             input logic [bdlp_pkg::CSR_W-1:0] bu);
      write_csr(bdlp_pkg::CSR_DEBOUNCE_LEN, dl);
      write_csr(bdlp_pkg::CSR_BLOCK_US, bu);
      repeat (n) push_request(random_request(), 1'b0, 3'b000);
      drain();
   endtask

   // response side: random stall bursts, plus one long hold-off on request
   initial begin
      int unsigned stall_left;
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            rsp_tready   = 1'b0;
            stall_left   = HOLD_CYCLES - 1;
         end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            rsp_tready = 1'b0;
            stall_left = $urandom_range(1, 11) - 1;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_button_leds.size() == 0) begin
            errors++;
            $display("%0t unexpected response: expected none, got %b", $realtime, rsp_tdata);
         end else begin
            want = awaited_button_leds.pop_front();
            for (int f = 0; f < 3; f++) begin
               if (rsp_tdata[f] !== want[f]) begin
                  errors++;
                  $display("%0t %s mismatch: expected %b, got %b",
                           $realtime, rsp_field_name[f], want[f], rsp_tdata[f]);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tuser    = '0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = bdlp_pkg::CSR_DEBOUNCE_LEN;
      csr_data     = '0;
      errors       = 0;
      quiet_cycles = 0;
      no_idle      = 1'b0;
      hold_rsp_req = 1'b0;
      raw_level    = 1'b0;

      deb_len   = bdlp_pkg::DEBOUNCE_LEN_RESET;
      blk_us    = bdlp_pkg::BLOCK_US_RESET;
      btn_state = 1'b0;
      holdoff   = '0;
      pwm_idx   = 0;
      drive_lvl = '{0, 0};
      for (int c = 0; c < bdlp_pkg::NUM_COLORS; c++) begin
         col_style[c] = 2'd0;
         col_lvl[c]   = '0;
         col_rem[c]   = 0;
      end

      dir_rows = '{
         '{'{bdlp_pkg::REQ_SAMPLE, 1'b0, 2'd0, bdlp_pkg::COLOR_RED, 10'd0, 24'd0},
           1'b1, 3'b000},
         // unused kind with every field high changes nothing
         '{'{bdlp_pkg::REQ_NONE, 1'b1, 2'd3, bdlp_pkg::COLOR_ALL, 10'd1023, 24'hFFFFFF},
           1'b1, 3'b000},
         '{'{bdlp_pkg::REQ_SAMPLE, 1'b1, 2'd0, bdlp_pkg::COLOR_RED, 10'd0, 24'd0},
           1'b1, 3'b001},
         // inside the hold-off the raw bit is ignored
         '{'{bdlp_pkg::REQ_SAMPLE, 1'b0, 2'd0, bdlp_pkg::COLOR_RED, 10'd0, 24'd0},
           1'b1, 3'b001},
         '{'{bdlp_pkg::REQ_SET, 1'b0, 2'd1, bdlp_pkg::COLOR_RED, 10'd512, 24'hFFFFFF},
           1'b0, 3'b000},
         '{'{bdlp_pkg::REQ_SET, 1'b0, 2'd3, bdlp_pkg::COLOR_GREEN, 10'd1023, 24'd1},
           1'b0, 3'b000},
         '{'{bdlp_pkg::REQ_SET, 1'b0, 2'd2, bdlp_pkg::COLOR_YELLOW, 10'd0, 24'd5000},
           1'b0, 3'b000},
         '{'{bdlp_pkg::REQ_BLOCK, 1'b0, 2'd0, bdlp_pkg::COLOR_RED, 10'd0, 24'd0},
           1'b0, 3'b000},
         '{'{bdlp_pkg::REQ_SAMPLE, 1'b0, 2'd0, bdlp_pkg::COLOR_RED, 10'd0, 24'd0},
           1'b0, 3'b000},
         '{'{bdlp_pkg::REQ_SAMPLE, 1'b0, 2'd0, bdlp_pkg::COLOR_RED, 10'd0, 24'd0},
           1'b0, 3'b000},
         '{'{bdlp_pkg::REQ_SAMPLE, 1'b1, 2'd0, bdlp_pkg::COLOR_RED, 10'd0, 24'd0},
           1'b0, 3'b000},
         '{'{bdlp_pkg::REQ_SAMPLE, 1'b0, 2'd0, bdlp_pkg::COLOR_RED, 10'd0, 24'd0},
           1'b0, 3'b000},
         // short green duration has saturated to zero by now
         '{'{bdlp_pkg::REQ_BLOCK, 1'b0, 2'd0, bdlp_pkg::COLOR_RED, 10'd0, 24'd0},
           1'b0, 3'b000},
         '{'{bdlp_pkg::REQ_SAMPLE, 1'b0, 2'd0, bdlp_pkg::COLOR_RED, 10'd0, 24'd0},
           1'b0, 3'b000},
         '{'{bdlp_pkg::REQ_SAMPLE, 1'b0, 2'd0, bdlp_pkg::COLOR_RED, 10'd0, 24'd0},
           1'b0, 3'b000},
         // above full scale
         '{'{bdlp_pkg::REQ_SET, 1'b0, 2'd1, bdlp_pkg::COLOR_YELLOW, 10'd1023, 24'd999},
           1'b0, 3'b000},
         '{'{bdlp_pkg::REQ_BLOCK, 1'b0, 2'd0, bdlp_pkg::COLOR_RED, 10'd0, 24'd0},
           1'b0, 3'b000},
         '{'{bdlp_pkg::REQ_SAMPLE, 1'b0, 2'd0, bdlp_pkg::COLOR_RED, 10'd0, 24'd0},
           1'b0, 3'b000},
         '{'{bdlp_pkg::REQ_SAMPLE, 1'b0, 2'd0, bdlp_pkg::COLOR_RED, 10'd0, 24'd0},
           1'b0, 3'b000},
         // style off blanks every colour
         '{'{bdlp_pkg::REQ_SET, 1'b0, 2'd0, bdlp_pkg::COLOR_ALL, 10'd100, 24'd10},
           1'b0, 3'b000},
         '{'{bdlp_pkg::REQ_BLOCK, 1'b0, 2'd0, bdlp_pkg::COLOR_RED, 10'd0, 24'd0},
           1'b0, 3'b000},
         '{'{bdlp_pkg::REQ_SAMPLE, 1'b0, 2'd0, bdlp_pkg::COLOR_RED, 10'd0, 24'd0},
           1'b0, 3'b000},
         '{'{bdlp_pkg::REQ_SET, 1'b0, 2'd2, bdlp_pkg::COLOR_ALL, 10'd512, 24'd2000},
           1'b0, 3'b000},
         '{'{bdlp_pkg::REQ_BLOCK, 1'b0, 2'd0, bdlp_pkg::COLOR_RED, 10'd0, 24'd0},
           1'b0, 3'b000},
         '{'{bdlp_pkg::REQ_SAMPLE, 1'b1, 2'd0, bdlp_pkg::COLOR_RED, 10'd0, 24'd0},
           1'b0, 3'b000}
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         push_request(dir_rows[i].req, dir_rows[i].known, dir_rows[i].rsp);
      drain();

      hold_rsp_req = 1'b1;
      run_random(250, 16'd0, 16'd1);
      run_random(200, 16'hFFFF, 16'hFFFF);
      run_random(300, 16'($urandom_range(1, 7)), 16'($urandom_range(1, 3000)));
      no_idle = 1'b1;
      run_random(280, 16'($urandom_range(0, 20)), 16'd500);

      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
